// File: hdl/infix_to_postfix_converter_unit_defines.svh
// Assertion macros for the infix to postfix converter.
// Define NO_ASSERTIONS to compile every check away.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ITP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itp: same-cycle check failed");

// next-cycle implication
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itp: next-cycle check failed");

`else

`define ITP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/itp_pkg.sv
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 8;

    // ASCII codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // operator codes held on the stack
    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_UNARY = 3'd5
    } t_op_code;

    // class of the previous significant character
    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_OPEN  = 2'd1,
        CLS_OPER  = 2'd2,
        CLS_VALUE = 2'd3
    } t_cls;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POPCHK,
        S_POP_SP,
        S_FLUSH_SP,
        S_FLUSH,
        S_FL_WAIT,
        S_FL_PSP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic     push;
        logic     pop;
        t_op_code code;
    } t_stk_cmd;

    typedef struct packed {
        logic     empty;
        logic     full;
        logic     no_open;
        t_op_code top;
    } t_stk_stat;

    function automatic logic [7:0] code_char(input t_op_code code);
        logic [7:0] ch;
        case (code)
            OP_OPEN:  ch = CH_OPEN;
            OP_ADD:   ch = CH_PLUS;
            OP_SUB:   ch = CH_MINUS;
            OP_MUL:   ch = CH_STAR;
            OP_DIV:   ch = CH_SLASH;
            OP_UNARY: ch = CH_UNDER;
            default:  ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // lower value binds tighter
    function automatic logic [1:0] prio(input t_op_code code);
        logic [1:0] p;
        case (code)
            OP_ADD, OP_SUB: p = 2'd2;
            OP_MUL, OP_DIV: p = 2'd1;
            default:        p = 2'd3;
        endcase
        return p;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_UA && c <= CH_UZ) || (c == CH_DOT);
    endfunction

endpackage

`default_nettype wire

// File: hdl/itp_stack.sv
`default_nettype none

module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire itp_pkg::t_stk_cmd i_cmd,
    output itp_pkg::t_stk_stat     o_stat
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    t_op_code         mem [STACK_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_open_cnt, n_open_cnt;
    t_op_code         r_top;
    logic [AW-1:0]    rd_addr;
    logic             empty, full, do_push, do_pop;

    assign empty   = (r_cnt == '0);
    assign full    = (r_cnt == CNT_W'(STACK_DEPTH));
    assign do_push = i_cmd.push && !full;
    assign do_pop  = i_cmd.pop && !empty;
    assign rd_addr = AW'(r_cnt - CNT_W'(1));

    // depth and count of '(' entries
    always_comb begin
        n_cnt      = r_cnt;
        n_open_cnt = r_open_cnt;
        if (do_push) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (i_cmd.code == OP_OPEN) begin
                n_open_cnt = r_open_cnt + CNT_W'(1);
            end
        end else if (do_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_top == OP_OPEN && r_open_cnt != '0) begin
                n_open_cnt = r_open_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_open_cnt <= '0;
        end else begin
            r_cnt      <= n_cnt;
            r_open_cnt <= n_open_cnt;
        end
    end

    // stack memory: one write port, top-of-stack read registered
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_cnt[AW-1:0]] <= i_cmd.code;
        end
        r_top <= mem[rd_addr];
    end

    // top is valid in the cycle after the depth settles
    assign o_stat = '{empty: empty, full: full, no_open: (r_open_cnt == '0), top: r_top};

endmodule

`default_nettype wire

// File: hdl/infix_to_postfix_converter_unit.sv
// Infix to postfix converter (shunting-yard).
// Input channel: one ASCII character per beat on i_char_in, i_expr_last marks
// the final character. A beat is taken when i_in_valid is high and o_in_stall
// is low. Output channel: one postfix character per beat, accepted when
// o_out_valid is high and i_out_stall is low; o_run_last flags the last beat
// caused by an input beat, o_expr_done the terminator beat of an expression.
// One input beat is worked on at a time. An operand or a dropped character
// goes from decode to the finish state and back to idle, as do '(' and unary
// minus; its result passes through the hold register to the output register.
// Binary operators and ')' add a precedence check and, per popped operator, a
// step for its character and one for the space; the final beat adds a closing
// space slot, each flushed operator with its space, a wait per discarded '('
// and the terminator. The operator stack sits in a memory with a registered
// read, so each pop waits for the new top.
// Reset empties the stack and returns to the start of an expression.
// A stall on the output holds the current beat; the converter stops as soon
// as its one-beat hold register and the output register are both full.
`default_nettype none

`include "infix_to_postfix_converter_unit_defines.svh"

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_expr_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_char_out,
    output logic            o_char_valid,
    output logic            o_run_last,
    output logic            o_expr_done,
    output logic            o_syntax_error
);
    import itp_pkg::*;

    t_state     r_state, n_state;
    logic [7:0] r_char;
    logic       r_last;

    // hold register: newest result, waits until its run_last is known
    logic       r_hold_vld, n_hold_vld;
    logic [7:0] r_hold_char, n_hold_char;
    logic       r_hold_cv, n_hold_cv;
    logic       r_hold_done, n_hold_done;

    // output register
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_char, n_o_char;
    logic       r_o_cv, n_o_cv;
    logic       r_o_rl, n_o_rl;
    logic       r_o_done, n_o_done;
    logic       r_o_err, n_o_err;

    // expression state
    logic       r_in_op, n_in_op;
    t_cls       r_prev, n_prev;
    logic       r_err, n_err;
    logic       r_item_err, n_item_err;

    t_stk_cmd   stk_cmd;
    t_stk_stat  stk_stat;

    logic       accept_in, out_take, out_free, can_emit, fin_ok;
    logic       c_ws, c_opnd, c_open, c_close, c_op_vld, c_bad, c_unary, c_pass;
    t_op_code   c_op;
    logic       pop_ok, item_err;
    logic       e_go, e_cv, e_done;
    logic [7:0] e_char;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    // handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign out_take   = r_o_valid && !i_out_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign can_emit   = !r_hold_vld || out_free;
    assign fin_ok     = !r_hold_vld || out_free;

    // character decode
    always_comb begin
        c_op_vld = 1'b1;
        case (r_char)
            CH_PLUS:  c_op = OP_ADD;
            CH_MINUS: c_op = OP_SUB;
            CH_STAR:  c_op = OP_MUL;
            CH_SLASH: c_op = OP_DIV;
            default: begin
                c_op     = OP_OPEN;
                c_op_vld = 1'b0;
            end
        endcase
    end

    assign c_ws    = is_ws(r_char);
    assign c_opnd  = is_operand(r_char);
    assign c_open  = (r_char == CH_OPEN);
    assign c_close = (r_char == CH_CLOSE);
    assign c_bad   = !c_ws && !c_opnd && !c_open && !c_close && !c_op_vld;
    assign c_unary = c_op_vld && (c_op == OP_SUB) && (r_prev != CLS_VALUE);
    // characters that never touch the stack in the main step
    assign c_pass  = c_ws || c_opnd || c_bad || (r_last && !c_close);

    // pop test against the current top
    assign pop_ok = !stk_stat.empty && (stk_stat.top != OP_OPEN) &&
                    (c_close || (stk_stat.top == OP_UNARY) ||
                     (prio(c_op) >= prio(stk_stat.top)));

    // error of this beat, known before any result leaves
    always_comb begin
        item_err = r_err;
        if (c_ws || c_opnd) begin
            item_err = r_err;
        end else if (c_bad) begin
            item_err = 1'b1;
        end else if (c_close) begin
            if (stk_stat.no_open) begin
                item_err = 1'b1;
            end
        end else if (!r_last) begin
            if (c_open || c_unary) begin
                if (stk_stat.full) begin
                    item_err = 1'b1;
                end
            end else if (stk_stat.full &&
                         ((stk_stat.top == OP_OPEN) ||
                          ((c_op == OP_MUL || c_op == OP_DIV) &&
                           (stk_stat.top == OP_ADD || stk_stat.top == OP_SUB)))) begin
                item_err = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (c_pass) begin
                    n_state = r_last ? S_FLUSH_SP : S_FIN;
                end else if (c_open || c_unary) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_POPCHK;
                end
            end
            S_POPCHK: begin
                if (pop_ok) begin
                    n_state = can_emit ? S_POP_SP : S_POPCHK;
                end else if (c_close && r_last) begin
                    n_state = S_FLUSH_SP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_SP: begin
                n_state = can_emit ? S_POPCHK : S_POP_SP;
            end
            S_FLUSH_SP: begin
                n_state = (!r_in_op || can_emit) ? S_FLUSH : S_FLUSH_SP;
            end
            S_FLUSH: begin
                if (stk_stat.empty) begin
                    n_state = can_emit ? S_FIN : S_FLUSH;
                end else if (stk_stat.top == OP_OPEN) begin
                    n_state = S_FL_WAIT;
                end else begin
                    n_state = can_emit ? S_FL_PSP : S_FLUSH;
                end
            end
            S_FL_WAIT: begin
                n_state = S_FLUSH;
            end
            S_FL_PSP: begin
                n_state = can_emit ? S_FLUSH : S_FL_PSP;
            end
            S_FIN: begin
                n_state = fin_ok ? S_IDLE : S_FIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs: stack commands, emitted result, expression state
    always_comb begin
        stk_cmd    = '{push: 1'b0, pop: 1'b0, code: OP_OPEN};
        e_go       = 1'b0;
        e_char     = CH_SPACE;
        e_cv       = 1'b1;
        e_done     = 1'b0;
        n_in_op    = r_in_op;
        n_prev     = r_prev;
        n_err      = r_err;
        n_item_err = r_item_err;
        case (r_state)
            S_DECODE: begin
                n_item_err = item_err;
                n_err      = item_err;
                if (c_pass) begin
                    if (c_opnd) begin
                        e_go    = 1'b1;
                        e_char  = r_char;
                        n_in_op = 1'b1;
                        n_prev  = CLS_VALUE;
                    end
                end else begin
                    // close the operand run
                    if (r_in_op) begin
                        e_go    = 1'b1;
                        n_in_op = 1'b0;
                    end
                    if (c_open) begin
                        stk_cmd.push = !stk_stat.full;
                        stk_cmd.code = OP_OPEN;
                        n_prev       = CLS_OPEN;
                    end else if (c_unary) begin
                        stk_cmd.push = !stk_stat.full;
                        stk_cmd.code = OP_UNARY;
                        n_prev       = CLS_OPER;
                    end
                end
            end
            S_POPCHK: begin
                if (pop_ok) begin
                    if (can_emit) begin
                        e_go        = 1'b1;
                        e_char      = code_char(stk_stat.top);
                        stk_cmd.pop = 1'b1;
                    end
                end else if (c_close) begin
                    // drop the matching '('
                    stk_cmd.pop = !stk_stat.empty;
                    n_prev      = CLS_VALUE;
                end else begin
                    stk_cmd.push = !stk_stat.full;
                    stk_cmd.code = c_op;
                    n_prev       = CLS_OPER;
                end
            end
            S_POP_SP, S_FL_PSP: begin
                e_go = can_emit;
            end
            S_FLUSH_SP: begin
                if (r_in_op && can_emit) begin
                    e_go    = 1'b1;
                    n_in_op = 1'b0;
                end
            end
            S_FLUSH: begin
                if (stk_stat.empty) begin
                    if (can_emit) begin
                        e_go   = 1'b1;
                        e_char = CH_NUL;
                        e_cv   = 1'b0;
                        e_done = 1'b1;
                    end
                end else if (stk_stat.top == OP_OPEN) begin
                    stk_cmd.pop = 1'b1;
                end else if (can_emit) begin
                    e_go        = 1'b1;
                    e_char      = code_char(stk_stat.top);
                    stk_cmd.pop = 1'b1;
                end
            end
            S_FIN: begin
                // back to start of expression after the terminator
                if (fin_ok && r_last) begin
                    n_in_op = 1'b0;
                    n_prev  = CLS_START;
                    n_err   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // hold and output registers
    always_comb begin
        n_hold_vld  = r_hold_vld;
        n_hold_char = r_hold_char;
        n_hold_cv   = r_hold_cv;
        n_hold_done = r_hold_done;
        n_o_valid   = r_o_valid;
        n_o_char    = r_o_char;
        n_o_cv      = r_o_cv;
        n_o_rl      = r_o_rl;
        n_o_done    = r_o_done;
        n_o_err     = r_o_err;
        if (out_take) begin
            n_o_valid = 1'b0;
        end
        if (e_go) begin
            // a newer result follows, so the held one is not the last
            if (r_hold_vld) begin
                n_o_valid = 1'b1;
                n_o_char  = r_hold_char;
                n_o_cv    = r_hold_cv;
                n_o_rl    = 1'b0;
                n_o_done  = r_hold_done;
                n_o_err   = r_item_err;
            end
            n_hold_vld  = 1'b1;
            n_hold_char = e_char;
            n_hold_cv   = e_cv;
            n_hold_done = e_done;
        end else if (r_state == S_FIN && r_hold_vld && out_free) begin
            n_o_valid  = 1'b1;
            n_o_char   = r_hold_char;
            n_o_cv     = r_hold_cv;
            n_o_rl     = 1'b1;
            n_o_done   = r_hold_done;
            n_o_err    = r_item_err;
            n_hold_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hold_vld <= 1'b0;
            r_o_valid  <= 1'b0;
            r_in_op    <= 1'b0;
            r_prev     <= CLS_START;
            r_err      <= 1'b0;
            r_item_err <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hold_vld <= n_hold_vld;
            r_o_valid  <= n_o_valid;
            r_in_op    <= n_in_op;
            r_prev     <= n_prev;
            r_err      <= n_err;
            r_item_err <= n_item_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_char <= i_char_in;
            r_last <= i_expr_last;
        end
        r_hold_char <= n_hold_char;
        r_hold_cv   <= n_hold_cv;
        r_hold_done <= n_hold_done;
        r_o_char    <= n_o_char;
        r_o_cv      <= n_o_cv;
        r_o_rl      <= n_o_rl;
        r_o_done    <= n_o_done;
        r_o_err     <= n_o_err;
    end

    assign o_out_valid    = r_o_valid;
    assign o_char_out     = r_o_char;
    assign o_char_valid   = r_o_cv;
    assign o_run_last     = r_o_rl;
    assign o_expr_done    = r_o_done;
    assign o_syntax_error = r_o_err;

    // checks
    `ITP_ASSERT_IMPLIES(a_term_shape, i_clk, i_rst_n,
                        o_out_valid && o_expr_done, o_run_last && !o_char_valid)
    `ITP_ASSERT_IMPLIES(a_idle_hold_empty, i_clk, i_rst_n, r_state == S_IDLE, !r_hold_vld)
    `ITP_ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, stk_cmd.push, !stk_stat.full)
    `ITP_ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, stk_cmd.pop, !stk_stat.empty)
    `ITP_ASSERT_NEXT(a_expr_end_clean, i_clk, i_rst_n,
                     r_state == S_FIN && fin_ok && r_last,
                     stk_stat.empty && !r_err && r_prev == CLS_START)

endmodule

`default_nettype wire

// File: test/infix_to_postfix_converter_unit_checker.sv
module infix_to_postfix_converter_unit_checker #(
    parameter int DEPTH      = itp_pkg::STACK_DEPTH_DEF,
    parameter int REPORT_MAX = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_expr_last,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_char_out,
    input  wire logic       i_char_valid,
    input  wire logic       i_run_last,
    input  wire logic       i_expr_done,
    input  wire logic       i_syntax_error,
    output int              o_mismatches,
    output int              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    // one output beat as the converter should produce it
    typedef struct packed {
        logic [7:0] ch;
        logic       ch_ok;
        logic       run_end;
        logic       done;
        logic       err;
    } t_postfix_beat;

    // predictor state
    t_op_code      op_stk [DEPTH];
    int            stk_n;
    t_cls          last_cls;
    logic          mid_operand;
    logic          err_flag;

    t_postfix_beat item_beats[$];    // beats caused by the current input beat
    t_postfix_beat postfix_q[$];     // expected beats not yet seen
    int            bad_beats = 0;
    int            backlog   = 0;

    assign o_mismatches  = bad_beats;
    assign o_outstanding = backlog;

    function automatic logic [7:0] glyph(input t_op_code op);
        case (op)
            OP_ADD:   return CH_PLUS;
            OP_SUB:   return CH_MINUS;
            OP_MUL:   return CH_STAR;
            OP_DIV:   return CH_SLASH;
            OP_UNARY: return CH_UNDER;
            default:  return CH_OPEN;
        endcase
    endfunction

    // lower rank binds tighter; '(' and unary sit at the top rank
    function automatic int rank(input t_op_code op);
        case (op)
            OP_ADD, OP_SUB: return 2;
            OP_MUL, OP_DIV: return 1;
            default:        return 3;
        endcase
    endfunction

    function automatic t_op_code stack_top();
        return (stk_n == 0) ? OP_OPEN : op_stk[stk_n - 1];
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic ok, input logic fin);
        t_postfix_beat b;
        b = '{ch: c, ch_ok: ok, run_end: 1'b0, done: fin, err: 1'b0};
        item_beats.insert(item_beats.size(), b);
    endfunction

    function automatic void pop_to_output();
        t_op_code t;
        t = stack_top();
        if (stk_n > 0) stk_n--;
        add_char(glyph(t), 1'b1, 1'b0);
        add_char(CH_SPACE, 1'b1, 1'b0);
    endfunction

    // a push onto a full stack is lost and flags the expression
    function automatic void push_op(input t_op_code op);
        if (stk_n >= DEPTH) begin
            err_flag = 1'b1;
        end else begin
            op_stk[stk_n] = op;
            stk_n++;
        end
    endfunction

    function automatic void clear_expr();
        stk_n       = 0;
        last_cls    = CLS_START;
        mid_operand = 1'b0;
        err_flag    = 1'b0;
    endfunction

    // shunting-yard step for one input character
    function automatic void convert_char(input logic [7:0] c, input logic fin);
        t_op_code op;
        logic     is_op;
        logic     blank;
        logic     operand_ch;
        logic     err_now;
        item_beats.delete();
        blank      = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        operand_ch = (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
                     (c >= CH_UA && c <= CH_UZ) || (c == CH_DOT);
        is_op = 1'b1;
        op    = OP_OPEN;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  is_op = 1'b0;
        endcase

        if (blank) begin
            // whitespace leaves everything as it is
        end else if (operand_ch) begin
            add_char(c, 1'b1, 1'b0);
            mid_operand = 1'b1;
            last_cls    = CLS_VALUE;
        end else if (c != CH_OPEN && c != CH_CLOSE && !is_op) begin
            err_flag = 1'b1;
        end else if (fin && c != CH_CLOSE) begin
            // operator or '(' with nothing after it
        end else begin
            if (mid_operand) begin
                add_char(CH_SPACE, 1'b1, 1'b0);
                mid_operand = 1'b0;
            end
            if (c == CH_OPEN) begin
                push_op(OP_OPEN);
                last_cls = CLS_OPEN;
            end else if (c == CH_CLOSE) begin
                while (stk_n > 0 && stack_top() != OP_OPEN) pop_to_output();
                if (stk_n > 0) stk_n--;
                else err_flag = 1'b1;
                last_cls = CLS_VALUE;
            end else begin
                if (op == OP_SUB && last_cls != CLS_VALUE) begin
                    push_op(OP_UNARY);
                end else begin
                    while (stk_n > 0 && (stack_top() == OP_UNARY ||
                                         rank(op) >= rank(stack_top()))) begin
                        pop_to_output();
                    end
                    push_op(op);
                end
                last_cls = CLS_OPER;
            end
        end

        err_now = err_flag;

        // final character: flush the stack, drop stray '(' and terminate
        if (fin) begin
            if (mid_operand) add_char(CH_SPACE, 1'b1, 1'b0);
            while (stk_n > 0) begin
                if (stack_top() == OP_OPEN) stk_n--;
                else pop_to_output();
            end
            add_char(CH_NUL, 1'b0, 1'b1);
            clear_expr();
        end

        foreach (item_beats[k]) begin
            item_beats[k].err     = err_now;
            item_beats[k].run_end = (k == item_beats.size() - 1);
            postfix_q.insert(postfix_q.size(), item_beats[k]);
        end
    endfunction

    function automatic void check_beat();
        t_postfix_beat got;
        t_postfix_beat want;
        got = '{ch: i_char_out, ch_ok: i_char_valid, run_end: i_run_last,
                done: i_expr_done, err: i_syntax_error};
        if (postfix_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= REPORT_MAX)
                $display("%0t: unexpected beat: char %02h valid %b last %b done %b err %b",
                         $realtime, got.ch, got.ch_ok, got.run_end, got.done, got.err);
        end else begin
            want = postfix_q.pop_front();
            if (got !== want) begin
                bad_beats++;
                if (bad_beats <= REPORT_MAX) begin
                    $display("%0t: beat mismatch, exp char %02h valid %b last %b done %b err %b",
                             $realtime, want.ch, want.ch_ok, want.run_end, want.done,
                             want.err);
                    $display("%0t:                got char %02h valid %b last %b done %b err %b",
                             $realtime, got.ch, got.ch_ok, got.run_end, got.done, got.err);
                end
            end
        end
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_expr();
            postfix_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) convert_char(i_char_in, i_expr_last);
            if (i_out_valid && !i_out_stall) check_beat();
        end
        backlog = postfix_q.size();
    end

endmodule

// File: test/infix_to_postfix_converter_unit_tb.sv
module infix_to_postfix_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int ITEM_TARGET  = 460;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_in   = 8'h00;
    logic       expr_last = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic       syntax_error;

    int         mismatches;
    int         outstanding;
    logic       calm        = 1'b0;
    int         useful_cnt  = 0;
    int         cycle_count = 0;
    int         stall_left  = 0;
    logic [7:0] expr_buf[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    infix_to_postfix_converter_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_char_in      (char_in),
        .i_expr_last    (expr_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_char_out     (char_out),
        .o_char_valid   (char_valid),
        .o_run_last     (run_last),
        .o_expr_done    (expr_done),
        .o_syntax_error (syntax_error)
    );

    infix_to_postfix_converter_unit_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_in      (char_in),
        .i_expr_last    (expr_last),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_char_out     (char_out),
        .i_char_valid   (char_valid),
        .i_run_last     (run_last),
        .i_expr_done    (expr_done),
        .i_syntax_error (syntax_error),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // hard stop
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output back-pressure: random stall bursts mixed with clean stretches
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(0, 14);
                end
                1: begin
                    out_stall  <= 1'b0;
                    stall_left <= $urandom_range(20, 60);
                end
                default: begin
                    out_stall  <= 1'b0;
                    stall_left <= $urandom_range(0, 8);
                end
            endcase
        end
    end

    // one input beat, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        expr_last <= fin;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_expr();
        foreach (expr_buf[k]) send_char(expr_buf[k], k == expr_buf.size() - 1);
    endtask

    // wait until every expected beat is out, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_operand_char();
        case ($urandom_range(0, 6))
            0, 1:    return CH_0 + 8'($urandom_range(0, 9));
            2, 3:    return CH_LA + 8'($urandom_range(0, 25));
            4, 5:    return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_DOT;
        endcase
    endfunction

    function automatic logic [7:0] rand_binop();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // append a character that does work, sometimes followed by whitespace
    function automatic void put(input logic [7:0] c);
        expr_buf.insert(expr_buf.size(), c);
        useful_cnt++;
        if ($urandom_range(0, 9) == 0) expr_buf.insert(expr_buf.size(), rand_blank());
    endfunction

    // balanced-paren expression with random nesting, unary minus and operands
    function automatic void build_good_expr();
        int terms;
        int open_n;
        terms  = $urandom_range(1, 5);
        open_n = 0;
        for (int k = 0; k < terms; k++) begin
            if (k > 0) put(rand_binop());
            while (open_n < 9 && $urandom_range(0, 3) == 0) begin
                put(CH_OPEN);
                open_n++;
            end
            while ($urandom_range(0, 4) == 0) put(CH_MINUS);
            repeat ($urandom_range(1, 3)) put(rand_operand_char());
            while (open_n > 0 && $urandom_range(0, 2) == 0) begin
                put(CH_CLOSE);
                open_n--;
            end
        end
        repeat (open_n) put(CH_CLOSE);
        // dangling operator on the final beat now and then
        if ($urandom_range(0, 7) == 0) put(rand_binop());
    endfunction

    // token soup plus raw bytes
    function automatic void build_noise_expr();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 5))
                0:       put(rand_operand_char());
                1:       put(rand_binop());
                2:       put(CH_OPEN);
                3:       put(CH_CLOSE);
                4:       expr_buf.insert(expr_buf.size(), 8'($urandom_range(0, 255)));
                default: expr_buf.insert(expr_buf.size(), rand_blank());
            endcase
        end
    endfunction

    initial begin
        logic paused;
        paused = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // illegal byte, unary minus, whitespace, all operators, parens, dangling '+'
        expr_buf = '{8'hFF, CH_MINUS, CH_TAB, "a", CH_STAR, CH_OPEN, "0", CH_MINUS, ".",
                     CH_CLOSE, CH_SLASH, CH_SPACE, "Z", CH_PLUS};
        send_expr();
        // unmatched ')', stack overflow, open parens dropped at flush, NUL byte
        expr_buf = '{CH_CLOSE, CH_OPEN, CH_OPEN, CH_OPEN, CH_OPEN, CH_OPEN, CH_OPEN,
                     CH_OPEN, CH_OPEN, CH_OPEN, CH_NUL};
        send_expr();

        // random expressions
        while (useful_cnt < ITEM_TARGET) begin
            if (!paused && useful_cnt >= ITEM_TARGET / 2) begin
                drain();
                paused = 1'b1;
            end
            if (useful_cnt >= ITEM_TARGET * 4 / 5) calm <= 1'b1;
            expr_buf.delete();
            if ($urandom_range(0, 3) == 0) build_noise_expr();
            else build_good_expr();
            send_expr();
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
